// File: rtl/core/bbfa_pkg.sv
// bbfa_pkg: request and response payload types, function and status codes
// for the bitmap best-fit allocator; depends on nothing
package bbfa_pkg;

   // request function codes
   localparam logic FUNC_ALLOC   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_ZERO  = 2'd1;
   localparam logic [1:0] ST_NOFIT = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   // field widths fixed by the request and response formats
   localparam int SIZE_W    = 13;
   localparam int OFFSET_W  = 12;
   localparam int GRANTED_W = 9;

   typedef struct packed {
      logic                func;
      logic [SIZE_W-1:0]   size_bytes;
      logic [OFFSET_W-1:0] block_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [OFFSET_W-1:0]  result_offset;
      logic [GRANTED_W-1:0] granted_chunks;
   } rsp_type;

endpackage

// File: rtl/core/bitmap_best_fit_allocator.sv
// bitmap_best_fit_allocator: best-fit chunk allocator over a used-chunk bitmap ram
// depends on bbfa_pkg and bbfa_ram
//
// usage: a request transfers on a rising edge with start high and busy low.
// req_item.func selects allocate or release. every request gives exactly one
// response, shown on rsp_item for one cycle with rsp_strobe high; the receiver
// cannot stall it and must take it in that cycle.
// steps: S_DIV turns the byte size and the byte offset into chunk counts
// by reciprocal multiplication, then S_DECIDE picks the path. an allocate
// then scans the bitmap ram one chunk per cycle, picks the best fit in S_PICK,
// writes one chunk per cycle for the granted chunks and loads the response;
// when no run fits it answers with no write. a release skips the scan and
// writes its chunks free. other errors go straight to the response.
// one request is in flight at a time; busy stays high until the response cycle,
// and the next request can transfer in that cycle.
// reset: a clearing pass writes every bitmap entry free with busy high; no
// request is taken during it.
module bitmap_best_fit_allocator #(
   parameter int CHUNK_BYTES = 16,
   parameter int CHUNK_COUNT = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bbfa_pkg::req_type req_item,
   output logic              rsp_strobe,
   output bbfa_pkg::rsp_type rsp_item
);

   localparam int IW  = $clog2(CHUNK_COUNT);
   localparam int CW  = $clog2(CHUNK_COUNT + 1);
   localparam int SW  = bbfa_pkg::SIZE_W;
   localparam int OW  = bbfa_pkg::OFFSET_W;
   localparam int NW  = ((CW > SW) ? CW : SW) + 1;
   localparam int PW  = IW + SW;
   localparam int QN  = SW + 1;
   localparam int QL  = $clog2(CHUNK_BYTES);
   localparam int QMW = QN + 1;
   localparam int QPW = QN + QMW;

   localparam logic [IW-1:0]  LAST_IDX = IW'(CHUNK_COUNT - 1);
   localparam logic [CW-1:0]  COUNT_N  = CW'(CHUNK_COUNT);
   localparam logic [NW-1:0]  COUNT_NW = NW'(CHUNK_COUNT);
   localparam logic [QN-1:0]  ROUND_UP = QN'(CHUNK_BYTES - 1);
   localparam logic [QMW-1:0] RECIP    =
      QMW'(((1 << (QN + QL)) + CHUNK_BYTES - 1) / CHUNK_BYTES);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_DIV    = 8'b0000_0100,
      S_DECIDE = 8'b0000_1000,
      S_SCAN   = 8'b0001_0000,
      S_PICK   = 8'b0010_0000,
      S_WRITE  = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // request context
   logic                             func_ff, func_in;
   logic [bbfa_pkg::OFFSET_W-1:0]    offs_ff, offs_in;
   logic [SW-1:0]                    need_ff, need_in;
   logic [bbfa_pkg::OFFSET_W-1:0]    first_ff, first_in;
   logic [1:0]                       status_ff, status_in;

   // byte to chunk conversion
   logic [SW-1:0]  dvd_ff, dvd_in;
   logic [QN-1:0]  size_sum;
   logic [QPW-1:0] need_prod;
   logic [QPW-1:0] first_prod;

   // scan
   logic [CW-1:0] issue_ff, issue_in;
   logic          dv_ff, dv_in;
   logic [IW-1:0] data_idx_ff, data_idx_in;
   logic [CW-1:0] run_len_ff, run_len_in;
   logic [IW-1:0] run_start_ff, run_start_in;
   logic          found_ff, found_in;
   logic [CW-1:0] best_len_ff, best_len_in;
   logic [IW-1:0] best_start_ff, best_start_in;
   logic [CW-1:0] cand_len;
   logic [IW-1:0] cand_start;
   logic          cand_close;

   // writer
   logic [IW-1:0] wr_addr_ff, wr_addr_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          wr_val_ff, wr_val_in;

   // response
   logic              rsp_strobe_ff, rsp_strobe_in;
   bbfa_pkg::rsp_type rsp_ff, rsp_in;
   logic [PW-1:0]     offset_prod;

   // ram ports
   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   logic          mem_wr_data;
   logic          mem_rd_en;
   logic [IW-1:0] mem_rd_addr;
   logic          mem_rd_data;

   logic [NW-1:0] rel_end;

   bbfa_ram #(
      .WIDTH (1),
      .DEPTH (CHUNK_COUNT)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // bytes to chunks by reciprocal multiplication, exact over the operand range
   always_comb begin
      size_sum   = QN'(dvd_ff) + ROUND_UP;
      need_prod  = QPW'(size_sum) * QPW'(RECIP);
      first_prod = QPW'(offs_ff) * QPW'(RECIP);
   end

   // run that closes on the current bitmap bit
   always_comb begin
      cand_close = 1'b0;
      cand_len   = run_len_ff;
      cand_start = run_start_ff;
      if (dv_ff) begin
         if (mem_rd_data) begin
            cand_close = (run_len_ff != '0);
         end else begin
            cand_len   = run_len_ff + CW'(1);
            cand_start = (run_len_ff == '0) ? data_idx_ff : run_start_ff;
            cand_close = (data_idx_ff == LAST_IDX);
         end
      end
   end

   assign rel_end     = NW'(first_ff) + NW'(need_ff);
   assign offset_prod = PW'(best_start_ff) * PW'(CHUNK_BYTES);

   // control and datapath next state
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      offs_in       = offs_ff;
      need_in       = need_ff;
      first_in      = first_ff;
      status_in     = status_ff;
      dvd_in        = dvd_ff;
      issue_in      = issue_ff;
      dv_in         = 1'b0;
      data_idx_in   = data_idx_ff;
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      found_in      = found_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      wr_addr_in    = wr_addr_ff;
      remain_in     = remain_ff;
      wr_val_in     = wr_val_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = wr_addr_ff;
      mem_wr_data   = wr_val_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = issue_ff[IW-1:0];

      unique case (state_ff)
         // clearing pass after reset
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = 1'b0;
            wr_addr_in  = wr_addr_ff + IW'(1);
            if (wr_addr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         // wait for a request transfer
         S_IDLE: begin
            if (start) begin
               func_in  = req_item.func;
               offs_in  = req_item.block_offset;
               dvd_in   = req_item.size_bytes;
               state_in = S_DIV;
            end
         end
         // size to chunks (rounded up) and offset to first chunk
         S_DIV: begin
            need_in  = SW'(need_prod >> (QN + QL));
            first_in = OW'(first_prod >> (QN + QL));
            state_in = S_DECIDE;
         end
         // pick the path for this request
         S_DECIDE: begin
            status_in = bbfa_pkg::ST_OK;
            if (func_ff == bbfa_pkg::FUNC_ALLOC) begin
               if (need_ff == '0) begin
                  status_in = bbfa_pkg::ST_ZERO;
                  state_in  = S_RESP;
               end else begin
                  issue_in   = '0;
                  run_len_in = '0;
                  found_in   = 1'b0;
                  state_in   = S_SCAN;
               end
            end else begin
               if (rel_end > COUNT_NW) begin
                  status_in = bbfa_pkg::ST_RANGE;
                  state_in  = S_RESP;
               end else if (need_ff == '0) begin
                  state_in = S_RESP;
               end else begin
                  wr_addr_in = IW'(first_ff);
                  remain_in  = CW'(need_ff);
                  wr_val_in  = 1'b0;
                  state_in   = S_WRITE;
               end
            end
         end
         // walk the bitmap, tracking free runs and the best fit
         S_SCAN: begin
            if (issue_ff < COUNT_N) begin
               mem_rd_en   = 1'b1;
               issue_in    = issue_ff + CW'(1);
               dv_in       = 1'b1;
               data_idx_in = issue_ff[IW-1:0];
            end
            if (dv_ff) begin
               if (mem_rd_data) begin
                  run_len_in = '0;
               end else begin
                  run_len_in   = cand_len;
                  run_start_in = cand_start;
               end
               if (cand_close && (NW'(cand_len) >= NW'(need_ff)) &&
                   (!found_ff || (cand_len < best_len_ff))) begin
                  found_in      = 1'b1;
                  best_len_in   = cand_len;
                  best_start_in = cand_start;
               end
               if (data_idx_ff == LAST_IDX) begin
                  state_in = S_PICK;
               end
            end
         end
         // mark the chosen run or report no fit
         S_PICK: begin
            if (found_ff) begin
               wr_addr_in = best_start_ff;
               remain_in  = CW'(need_ff);
               wr_val_in  = 1'b1;
               state_in   = S_WRITE;
            end else begin
               status_in = bbfa_pkg::ST_NOFIT;
               state_in  = S_RESP;
            end
         end
         // one chunk written per cycle
         S_WRITE: begin
            mem_wr_en  = 1'b1;
            wr_addr_in = wr_addr_ff + IW'(1);
            remain_in  = remain_ff - CW'(1);
            if (remain_ff == CW'(1)) begin
               state_in = S_RESP;
            end
         end
         // load the response register
         S_RESP: begin
            rsp_strobe_in         = 1'b1;
            rsp_in.status         = status_ff;
            rsp_in.result_offset  = '0;
            rsp_in.granted_chunks = '0;
            if (status_ff == bbfa_pkg::ST_OK) begin
               rsp_in.granted_chunks = need_ff[bbfa_pkg::GRANTED_W-1:0];
               if (func_ff == bbfa_pkg::FUNC_ALLOC) begin
                  rsp_in.result_offset = offset_prod[bbfa_pkg::OFFSET_W-1:0];
               end
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         wr_addr_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
         dv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_addr_ff    <= wr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
         dv_ff         <= dv_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      offs_ff       <= offs_in;
      need_ff       <= need_in;
      first_ff      <= first_in;
      status_ff     <= status_in;
      dvd_ff        <= dvd_in;
      issue_ff      <= issue_in;
      data_idx_ff   <= data_idx_in;
      run_len_ff    <= run_len_in;
      run_start_ff  <= run_start_in;
      found_ff      <= found_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      remain_ff     <= remain_in;
      wr_val_ff     <= wr_val_in;
      rsp_ff        <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

`ifndef NO_ASSERTIONS
   // a response strobe lasts exactly one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   // a request transfer makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after request transfer");

   // the bitmap is never written while it is being scanned
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !mem_wr_en)
      else $error("bitmap write during scan");

   // a response only follows the response state
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == S_RESP))
      else $error("response strobe without response state");
`endif

endmodule

// File: rtl/core/bbfa_ram.sv
// bbfa_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
module bbfa_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
